// ===== rtl/core/tts_pkg.sv =====
// ----------------------------------------------------------------------------
// tts_pkg
// shared codes and widths for the tick task scheduler
// ----------------------------------------------------------------------------
package tts_pkg;

  // request codes on in_func
  localparam logic [1:0] FN_ADD  = 2'd0;
  localparam logic [1:0] FN_DEL  = 2'd1;
  localparam logic [1:0] FN_TICK = 2'd2;
  localparam logic [1:0] FN_DISP = 2'd3;

  // result codes on out_kind
  localparam logic [2:0] K_ADDED   = 3'd0;
  localparam logic [2:0] K_FULL    = 3'd1;
  localparam logic [2:0] K_DELETED = 3'd2;
  localparam logic [2:0] K_BADSLOT = 3'd3;
  localparam logic [2:0] K_TICK    = 3'd4;
  localparam logic [2:0] K_RUN     = 3'd5;
  localparam logic [2:0] K_NONE    = 3'd6;

  // run words emitted by one dispatch at most
  localparam int MAX_RESULTS = 32;
  localparam int NW          = $clog2(MAX_RESULTS + 1);

  localparam int TICK_W = 32;
  localparam int RUN_W  = 8;
  localparam int SLOT_W = 6;

  typedef logic [2:0] kind_t;

endpackage

// ===== rtl/core/tick_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// tick_task_scheduler
// table of periodic task slots with add, delete, tick and dispatch requests
// ----------------------------------------------------------------------------
// usage
//   in_* carries one request word per valid/ready handshake; in_func picks add,
//   delete, tick or dispatch. out_* returns result words; out_last marks the
//   final word of a request. add, delete and tick answer with one word,
//   dispatch with one run word per slot holding pending runs (up to 32),
//   or a single none-ready word.
// sequencing
//   in_ready is high only while the sequencer is idle; one request is worked
//   at a time. add and delete: the result is loaded into the output register
//   from S_ADD or S_DEL once that register is free. tick: one walk over the
//   used slots through a two-stage read/modify/write loop on the slot
//   memories, then the tick word. dispatch: a slot with no pending runs is
//   skipped; a slot with runs is read, then its run count written back as its
//   run word is loaded; with nothing pending, a none-ready word ends the walk.
// reset and stalls
//   reset empties the table (live and pending bits, used count cleared); the
//   slot memories are not cleared, a slot is written by add before any read.
//   a result waits in the output register while out_ready is low; the walk
//   holds before the next run word until that register is free.
// ----------------------------------------------------------------------------
module tick_task_scheduler
  import tts_pkg::*;
#(
  parameter int MAX_TASKS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_func,
  input  logic [TICK_W-1:0] in_delay_ticks,
  input  logic [TICK_W-1:0] in_period_ticks,
  input  logic [SLOT_W-1:0] in_slot,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_kind,
  output logic [SLOT_W-1:0] out_task_res,
  output logic              out_last
);

  // slot address width and a count width that can hold MAX_TASKS itself
  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_DEL,
    S_TICK,
    S_DISP,
    S_DRUN
  } state_t;

  state_t state_r, state_nxt;

  // latched request
  logic [TICK_W-1:0] dly_r, dly_nxt;
  logic [TICK_W-1:0] per_r, per_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  // table bookkeeping in flops: live slots and slots with pending runs
  logic [MAX_TASKS-1:0] live_r, live_nxt;
  logic [MAX_TASKS-1:0] pend_r, pend_nxt;
  logic [CW-1:0]        used_r, used_nxt;

  // walk counter and dispatch word count
  logic [CW-1:0] scan_r, scan_nxt;
  logic [NW-1:0] n_r, n_nxt;

  // tick write-back stage
  logic          p1_vld_r, p1_vld_nxt;
  logic [AW-1:0] p1_idx_r, p1_idx_nxt;

  // output register
  logic              out_vld_r, out_vld_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0] out_task_r, out_task_nxt;
  logic              out_last_r, out_last_nxt;

  // slot memories, one write and one registered read port each
  logic [TICK_W-1:0] dly_mem [MAX_TASKS];
  logic [TICK_W-1:0] per_mem [MAX_TASKS];
  logic [RUN_W-1:0]  run_mem [MAX_TASKS];
  logic [TICK_W-1:0] dly_q;
  logic [TICK_W-1:0] per_q;
  logic [RUN_W-1:0]  run_q;

  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              dly_we;
  logic              per_we;
  logic              run_we;
  logic [TICK_W-1:0] dly_wd;
  logic [RUN_W-1:0]  run_wd;

  logic          out_free;
  logic [AW-1:0] scan_idx;
  logic          more_pend;
  logic          disp_last;

  assign out_free = !out_vld_r || out_ready;
  assign scan_idx = scan_r[AW-1:0];

  // any pending slot beyond the one being dispatched
  always_comb begin
    more_pend = 1'b0;
    for (int j = 0; j < MAX_TASKS; j++) begin
      if (pend_r[j] && (CW'(j) > scan_r)) begin
        more_pend = 1'b1;
      end
    end
  end

  assign disp_last = !more_pend || (n_r == NW'(MAX_RESULTS - 1));

  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[wr_addr] <= dly_wd;
    end
    if (per_we) begin
      per_mem[wr_addr] <= per_r;
    end
    if (run_we) begin
      run_mem[wr_addr] <= run_wd;
    end
    if (rd_en) begin
      dly_q <= dly_mem[rd_addr];
      per_q <= per_mem[rd_addr];
      run_q <= run_mem[rd_addr];
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    dly_nxt      = dly_r;
    per_nxt      = per_r;
    slot_nxt     = slot_r;
    live_nxt     = live_r;
    pend_nxt     = pend_r;
    used_nxt     = used_r;
    scan_nxt     = scan_r;
    n_nxt        = n_r;
    p1_vld_nxt   = p1_vld_r;
    p1_idx_nxt   = p1_idx_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    out_kind_nxt = out_kind_r;
    out_task_nxt = out_task_r;
    out_last_nxt = out_last_r;

    rd_en   = 1'b0;
    rd_addr = scan_idx;
    wr_addr = p1_idx_r;
    dly_we  = 1'b0;
    per_we  = 1'b0;
    run_we  = 1'b0;
    dly_wd  = dly_r;
    run_wd  = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dly_nxt    = in_delay_ticks;
          per_nxt    = in_period_ticks;
          slot_nxt   = in_slot;
          scan_nxt   = '0;
          n_nxt      = '0;
          p1_vld_nxt = 1'b0;
          case (in_func)
            FN_ADD:  state_nxt = S_ADD;
            FN_DEL:  state_nxt = S_DEL;
            FN_TICK: state_nxt = S_TICK;
            default: state_nxt = S_DISP;
          endcase
        end
      end

      S_ADD: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_last_nxt = 1'b1;
          if (used_r == CW'(MAX_TASKS)) begin
            out_kind_nxt = K_FULL;
            out_task_nxt = '0;
          end else begin
            wr_addr                  = used_r[AW-1:0];
            dly_we                   = 1'b1;
            per_we                   = 1'b1;
            run_we                   = 1'b1;
            dly_wd                   = dly_r;
            run_wd                   = '0;
            live_nxt[used_r[AW-1:0]] = 1'b1;
            pend_nxt[used_r[AW-1:0]] = 1'b0;
            used_nxt                 = used_r + CW'(1);
            out_kind_nxt             = K_ADDED;
            out_task_nxt             = SLOT_W'(used_r);
          end
          state_nxt = S_IDLE;
        end
      end

      S_DEL: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_last_nxt = 1'b1;
          if ({1'b0, slot_r} >= 7'(MAX_TASKS)) begin
            out_kind_nxt = K_BADSLOT;
            out_task_nxt = '0;
          end else begin
            live_nxt[slot_r[AW-1:0]] = 1'b0;
            pend_nxt[slot_r[AW-1:0]] = 1'b0;
            out_kind_nxt             = K_DELETED;
            out_task_nxt             = slot_r;
          end
          state_nxt = S_IDLE;
        end
      end

      S_TICK: begin
        // write back the slot read in the previous cycle
        if (p1_vld_r) begin
          wr_addr = p1_idx_r;
          dly_we  = 1'b1;
          if (dly_q != '0) begin
            dly_wd = dly_q - TICK_W'(1);
          end else begin
            dly_wd             = per_q;
            run_we             = 1'b1;
            run_wd             = (run_q == '1) ? run_q : run_q + RUN_W'(1);
            pend_nxt[p1_idx_r] = 1'b1;
          end
        end
        p1_vld_nxt = 1'b0;
        if (scan_r < used_r) begin
          // read the next live slot, skip dead ones
          rd_en      = live_r[scan_idx];
          p1_vld_nxt = live_r[scan_idx];
          p1_idx_nxt = scan_idx;
          scan_nxt   = scan_r + CW'(1);
        end else if (!p1_vld_r && out_free) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = K_TICK;
          out_task_nxt = '0;
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      S_DISP: begin
        if (scan_r < used_r) begin
          if (!pend_r[scan_idx]) begin
            scan_nxt = scan_r + CW'(1);
          end else if (out_free) begin
            rd_en     = 1'b1;
            state_nxt = S_DRUN;
          end
        end else if (out_free) begin
          // walk ended with no run word, so nothing was pending
          out_vld_nxt  = 1'b1;
          out_kind_nxt = K_NONE;
          out_task_nxt = '0;
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      S_DRUN: begin
        // output register is free here: S_DISP checked it on the way in
        wr_addr            = scan_idx;
        run_we             = 1'b1;
        run_wd             = run_q - RUN_W'(1);
        pend_nxt[scan_idx] = (run_q != RUN_W'(1));
        out_vld_nxt        = 1'b1;
        out_kind_nxt       = K_RUN;
        out_task_nxt       = SLOT_W'(scan_idx);
        out_last_nxt       = disp_last;
        n_nxt              = n_r + NW'(1);
        scan_nxt           = scan_r + CW'(1);
        state_nxt          = disp_last ? S_IDLE : S_DISP;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      live_r    <= '0;
      pend_r    <= '0;
      used_r    <= '0;
      scan_r    <= '0;
      n_r       <= '0;
      p1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      live_r    <= live_nxt;
      pend_r    <= pend_nxt;
      used_r    <= used_nxt;
      scan_r    <= scan_nxt;
      n_r       <= n_nxt;
      p1_vld_r  <= p1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    dly_r      <= dly_nxt;
    per_r      <= per_nxt;
    slot_r     <= slot_nxt;
    p1_idx_r   <= p1_idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_task_r <= out_task_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_vld_r;
  assign out_kind     = out_kind_r;
  assign out_task_res = out_task_r;
  assign out_last     = out_last_r;

  // a slot with pending runs is always live
  a_pend_live: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r & ~live_r) == '0)
    else $error("pending run on a dead slot");

  // used count never passes the table size
  a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(MAX_TASKS))
    else $error("slot count past table size");

  // a slot picked for dispatch holds at least one run
  a_drun_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRUN |-> run_q != '0)
    else $error("dispatch of a slot with no runs");

  // the tick write-back stage is busy only during a tick walk
  a_p1_tick: assert property (@(posedge clk) disable iff (!rst_n)
    p1_vld_r |-> state_r == S_TICK)
    else $error("write-back stage active outside tick");

  // a run word is loaded only into a free output register
  a_drun_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DRUN |-> !out_vld_r)
    else $error("run word would overwrite a waiting result");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks the tick task scheduler word by word against a behavioral table of
// slots kept in the bench; request and result sides idle at random, and one
// long output stall fills the block up so that it holds off new requests
// ----------------------------------------------------------------------------
module tb_top;
  import tts_pkg::*;

  localparam int NTASK       = 32;
  localparam int LIMIT       = 2000000;  // cycles before the run is declared hung
  localparam int DRAIN       = 100;      // quiet cycles after the last expected word
  localparam int HOLD_CYCLES = 400;      // length of the long output stall

  // one result word as the block should present it
  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] idx;
    logic              last;
  } result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_func = FN_TICK;
  logic [TICK_W-1:0] in_delay_ticks = '0;
  logic [TICK_W-1:0] in_period_ticks = '0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        out_kind;
  logic [SLOT_W-1:0] out_task_res;
  logic              out_last;

  // bench copy of the slot table
  logic [TICK_W-1:0] t_delay [NTASK];
  logic [TICK_W-1:0] t_period [NTASK];
  logic [RUN_W-1:0]  t_runs [NTASK];
  logic              t_live [NTASK];
  int                t_used = 0;

  result_t     due_words[$];  // words the block still owes, oldest first
  result_t     head;
  int          errors = 0;
  int unsigned cycles = 0;
  logic        hold_out = 1'b0;  // asks the receiver for the long stall

  always #5 clk = ~clk;

  tick_task_scheduler #(
    .MAX_TASKS(NTASK)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_delay_ticks (in_delay_ticks),
    .in_period_ticks(in_period_ticks),
    .in_slot        (in_slot),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_task_res   (out_task_res),
    .out_last       (out_last)
  );

  initial begin
    for (int i = 0; i < NTASK; i++) begin
      t_live[i] = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // expected behavior
  // --------------------------------------------------------------------------
  function automatic void post_result(kind_t k, int idx, logic lst);
    result_t w;
    w.kind = k;
    w.idx  = idx[SLOT_W-1:0];
    w.last = lst;
    due_words.push_back(w);
  endfunction

  // updates the table for one accepted request and queues the words it causes
  task automatic schedule_request(input logic [1:0] fn, input logic [TICK_W-1:0] dly,
                                  input logic [TICK_W-1:0] per,
                                  input logic [SLOT_W-1:0] sl);
    int total;
    int n;
    total = 0;
    n = 0;
    case (fn)
      FN_ADD: begin
        // no reuse of deleted slots: the table only ever fills up
        if (t_used >= NTASK) begin
          post_result(K_FULL, 0, 1'b1);
        end else begin
          t_delay[t_used]  = dly;
          t_period[t_used] = per;
          t_runs[t_used]   = '0;
          t_live[t_used]   = 1'b1;
          post_result(K_ADDED, t_used, 1'b1);
          t_used++;
        end
      end
      FN_DEL: begin
        if (int'(sl) >= NTASK) begin
          post_result(K_BADSLOT, 0, 1'b1);
        end else begin
          // unused or already deleted slots are cleared just the same
          t_delay[sl]  = '0;
          t_period[sl] = '0;
          t_runs[sl]   = '0;
          t_live[sl]   = 1'b0;
          post_result(K_DELETED, int'(sl), 1'b1);
        end
      end
      FN_TICK: begin
        for (int i = 0; i < t_used; i++) begin
          if (t_live[i]) begin
            if (t_delay[i] != '0) begin
              t_delay[i] = t_delay[i] - TICK_W'(1);
            end else begin
              t_delay[i] = t_period[i];
              if (t_runs[i] != '1) begin
                t_runs[i] = t_runs[i] + RUN_W'(1);
              end
            end
          end
        end
        post_result(K_TICK, 0, 1'b1);
      end
      default: begin
        // count the run words first so the final one carries last
        for (int i = 0; i < t_used; i++) begin
          if (t_live[i] && t_runs[i] != '0) begin
            total++;
          end
        end
        if (total > MAX_RESULTS) begin
          total = MAX_RESULTS;
        end
        for (int i = 0; i < t_used && n < total; i++) begin
          if (t_live[i] && t_runs[i] != '0) begin
            t_runs[i] = t_runs[i] - RUN_W'(1);
            n++;
            post_result(K_RUN, i, n == total);
          end
        end
        if (total == 0) begin
          post_result(K_NONE, 0, 1'b1);
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // request side: called at a falling edge, returns at a falling edge
  // --------------------------------------------------------------------------
  task automatic offer_request(input logic [1:0] fn, input logic [TICK_W-1:0] dly,
                               input logic [TICK_W-1:0] per,
                               input logic [SLOT_W-1:0] sl);
    int r;
    int gap;
    in_func         = fn;
    in_delay_ticks  = dly;
    in_period_ticks = per;
    in_slot         = sl;
    in_valid        = 1'b1;
    @(posedge clk);
    while (in_ready !== 1'b1) begin
      @(posedge clk);
    end
    schedule_request(fn, dly, per, sl);
    @(negedge clk);
    // mostly back to back, sometimes a short pause, rarely a long one
    r = $urandom_range(0, 99);
    if (r < 62) begin
      gap = 0;
    end else if (r < 88) begin
      gap = $urandom_range(1, 3);
    end else if (r < 96) begin
      gap = $urandom_range(4, 8);
    end else begin
      gap = $urandom_range(15, 40);
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // tick counts: mostly small so tasks fire, sometimes any 32-bit value
  function automatic logic [TICK_W-1:0] pick_ticks(int small_max);
    if ($urandom_range(0, 99) < 85) begin
      return $urandom_range(0, small_max);
    end
    return $urandom;
  endfunction

  // any value the slot field can hold
  function automatic logic [SLOT_W-1:0] any_slot();
    return SLOT_W'($urandom_range(0, 63));
  endfunction

  // --------------------------------------------------------------------------
  // result side pacing
  // --------------------------------------------------------------------------
  initial begin : rx_pacing
    int r;
    int len;
    forever begin
      if (hold_out) begin
        // long stall so the block fills up and holds off requests
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_ready = 1'b1;
          len = 1;
        end else if (r < 88) begin
          out_ready = 1'b0;
          len = $urandom_range(1, 3);
        end else if (r < 96) begin
          out_ready = 1'b1;  // stretch with no stalls
          len = $urandom_range(20, 60);
        end else begin
          out_ready = 1'b0;
          len = $urandom_range(10, 40);
        end
        repeat (len) @(negedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // result check, sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (due_words.size() == 0) begin
        $display("%0t: unexpected word kind %0d task %0d last %0b", $time,
                 out_kind, out_task_res, out_last);
        errors++;
      end else begin
        head = due_words.pop_front();
        if (out_kind !== head.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, head.kind, out_kind);
          errors++;
        end
        if (out_task_res !== head.idx) begin
          $display("%0t: task_res expected %0d actual %0d", $time, head.idx,
                   out_task_res);
          errors++;
        end
        if (out_last !== head.last) begin
          $display("%0t: last expected %0b actual %0b", $time, head.last, out_last);
          errors++;
        end
      end
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               due_words.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // empty table, field extremes, every request and each corner of delete
  task automatic test_directed();
    offer_request(FN_DISP, '1, '1, '1);            // nothing ready on an empty table
    offer_request(FN_TICK, '1, '0, 6'd63);         // tick over no slots
    offer_request(FN_ADD, '0, '0, '0);             // slot 0 fires on every tick
    offer_request(FN_ADD, '1, '1, 6'd63);          // slot 1 all-ones delay, never due
    offer_request(FN_ADD, 32'd1, 32'd2, '0);       // slot 2
    offer_request(FN_ADD, '0, 32'h8000_0000, '1);  // slot 3 fires once, then waits
    offer_request(FN_TICK, '0, '0, '0);
    offer_request(FN_TICK, '0, '0, '0);
    offer_request(FN_TICK, '0, '0, '0);
    offer_request(FN_DISP, '0, '0, '0);
    offer_request(FN_DISP, '0, '0, '0);
    offer_request(FN_DEL, '1, '1, 6'd1);           // live slot
    offer_request(FN_DEL, '0, '0, 6'd1);           // already deleted
    offer_request(FN_DEL, '0, '0, 6'd20);          // not yet added
    offer_request(FN_DEL, '0, '0, 6'd32);          // first index past the table
    offer_request(FN_DEL, '0, '0, 6'd63);          // top of the slot field
    offer_request(FN_TICK, '0, '0, '0);
    offer_request(FN_DEL, '0, '0, 6'd0);           // slot with pending runs
    offer_request(FN_DISP, '0, '0, '0);            // emptied slot must stay quiet
    offer_request(FN_TICK, '0, '0, '0);
    offer_request(FN_DISP, '0, '0, '0);
    offer_request(FN_DISP, '0, '0, '0);
  endtask

  // one task due every tick, ticked once past the run counter's ceiling
  task automatic test_run_saturation();
    offer_request(FN_ADD, '0, '0, '0);
    repeat (256) begin
      offer_request(FN_TICK, $urandom, $urandom, any_slot());
    end
    repeat (2) begin
      offer_request(FN_DISP, $urandom, $urandom, any_slot());
    end
  endtask

  // mixed traffic, weighted toward tick and dispatch on a growing table
  task automatic test_random_traffic(input int count);
    int r;
    int add_pct;
    logic [SLOT_W-1:0] sl;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      // keep a few slots back for the full-table test
      add_pct = (t_used < 26) ? 14 : 3;
      if (r < add_pct) begin
        offer_request(FN_ADD, pick_ticks(4), pick_ticks(6), any_slot());
      end else if (r < add_pct + 8) begin
        // mostly slots in use, sometimes anything the field can hold
        if ($urandom_range(0, 99) < 80 && t_used > 0) begin
          sl = SLOT_W'($urandom_range(0, t_used - 1));
        end else begin
          sl = any_slot();
        end
        offer_request(FN_DEL, $urandom, $urandom, sl);
      end else if (r < 60) begin
        offer_request(FN_TICK, $urandom, $urandom, any_slot());
      end else begin
        offer_request(FN_DISP, $urandom, $urandom, any_slot());
      end
    end
  endtask

  // fill every slot, then add past the end and run long dispatches
  task automatic test_table_full();
    while (t_used < NTASK) begin
      offer_request(FN_ADD, $urandom_range(0, 2), $urandom_range(0, 3), any_slot());
    end
    offer_request(FN_ADD, '0, '0, '0);
    offer_request(FN_ADD, '1, '1, '1);
    repeat (6) begin
      offer_request(FN_TICK, '0, '0, '0);
    end
    repeat (3) begin
      offer_request(FN_DISP, '0, '0, '0);
    end
  endtask

  // receiver stops for a long stretch while requests keep coming
  task automatic test_output_stall();
    hold_out = 1'b1;
    repeat (4) begin
      offer_request(FN_TICK, $urandom, $urandom, any_slot());
      offer_request(FN_DISP, $urandom, $urandom, any_slot());
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_run_saturation();
    test_random_traffic(24);
    test_table_full();
    test_output_stall();
    in_valid = 1'b0;

    // wait for every owed word, then watch for strays
    while (due_words.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN) @(negedge clk);

    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tts_pkg.sv
rtl/core/tick_task_scheduler.sv
tb/sv/tb_top.sv
